@@ design/case_insensitive_substring_search_assert.svh @@
// assertion macros for the case-insensitive substring search block
`ifndef CASE_INSENSITIVE_SUBSTRING_SEARCH_ASSERT_SVH
`define CASE_INSENSITIVE_SUBSTRING_SEARCH_ASSERT_SVH

`ifndef SYNTH
`define CISS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CISS_ASSERT(lbl, prop, msg) \
  `CISS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define CISS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define CISS_ASSERT(lbl, prop, msg)
`endif

`endif

@@ design/ciss_pkg.sv @@
// types, constants and byte folding for the substring search
package ciss_pkg;

  localparam logic       ACT_PATTERN = 1'b0;
  localparam logic       ACT_TEXT    = 1'b1;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  typedef struct packed {
    logic pat_shift;
    logic pat_keep;
    logic txt_shift;
    logic txt_clear;
  } ciss_ctrl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ design/ciss_in_if.sv @@
// input channel: pattern and text bytes
interface ciss_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, action, data_byte, has_byte, last, input ready);
  modport sink   (input valid, action, data_byte, has_byte, last, output ready);
endinterface

@@ design/ciss_out_if.sv @@
// output channel: search result
interface ciss_out_if;
  logic valid;
  logic ready;
  logic found;
  logic pattern_overflow;

  modport source (output valid, found, pattern_overflow, input ready);
  modport sink   (input valid, found, pattern_overflow, output ready);
endinterface

@@ design/ciss_cell.sv @@
// one window cell: a pattern byte, a text byte, their valid bits and a compare
module ciss_cell
  import ciss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ciss_ctrl_t ctrl_i,
  input  logic [7:0] pat_i,
  input  logic       pval_i,
  input  logic [7:0] txt_i,
  input  logic       tval_i,
  output logic [7:0] pat_o,
  output logic       pval_o,
  output logic [7:0] txt_o,
  output logic       tval_o,
  output logic       hit_o
);

  logic [7:0] pat_q, txt_q;
  logic       pval_q, pval_d, tval_q, tval_d;

  always_comb begin
    pval_d = pval_q;
    if (ctrl_i.pat_shift) begin
      pval_d = pval_i;
    end else if (!ctrl_i.pat_keep) begin
      pval_d = 1'b0;
    end
    tval_d = tval_q;
    if (ctrl_i.txt_clear) begin
      tval_d = 1'b0;
    end else if (ctrl_i.txt_shift) begin
      tval_d = tval_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pval_q <= 1'b0;
      tval_q <= 1'b0;
    end else begin
      pval_q <= pval_d;
      tval_q <= tval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_shift) begin
      pat_q <= pat_i;
    end
    if (ctrl_i.txt_shift) begin
      txt_q <= txt_i;
    end
  end

  // neighbor sees no valid pattern byte once the pattern restarts
  assign pat_o  = pat_q;
  assign pval_o = pval_q & ctrl_i.pat_keep;
  assign txt_o  = txt_q;
  assign tval_o = tval_q;
  // compare against the window as it stands after this shift
  assign hit_o  = !pval_q || (tval_i && (txt_i == pat_q));

endmodule

@@ design/case_insensitive_substring_search.sv @@
// top level of the case-insensitive substring search
//
//  channel  dir  beat                                    done when
//  in_i     in   action, data_byte, has_byte, last       valid && ready
//  out_o    out  found, pattern_overflow                 valid && ready
//
//  one beat per cycle on in_i; a result appears the cycle after the last text beat
//  the figure is set by the cell row: every cell compares in parallel each cycle
//  reset clears all valid bits at once; no clearing pass
//  in_i stalls only while a result waits in the output register and out_o is not ready
`include "case_insensitive_substring_search_assert.svh"

module case_insensitive_substring_search
  import ciss_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ciss_in_if.sink    in_i,
  ciss_out_if.source out_o
);

  ciss_ctrl_t             ctrl;
  logic [7:0]             pat_vec [MAX_PATTERN];
  logic [7:0]             txt_vec [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pval_vec, tval_vec, hit_vec;

  logic       in_fire, is_pat, is_txt, pat_clear, drop, store_try, full_eff;
  logic       match, found_now, result_found, emit;
  logic [7:0] byte_folded;

  logic starting_q, starting_d, ovf_q, ovf_d, found_q, found_d;
  logic out_valid_q, out_valid_d, out_found_q, out_ovf_q;

  assign in_fire     = in_i.valid && in_i.ready;
  assign is_pat      = in_fire && (in_i.action == ACT_PATTERN);
  assign is_txt      = in_fire && (in_i.action == ACT_TEXT);
  assign byte_folded = fold_case(in_i.data_byte);
  assign pat_clear   = is_pat && starting_q;
  assign drop        = (in_i.data_byte == CHAR_PERCENT) && (starting_q || in_i.last);
  assign store_try   = is_pat && in_i.has_byte && !drop;
  assign full_eff    = pval_vec[MAX_PATTERN-1] && !pat_clear;

  assign ctrl.pat_shift = store_try && !full_eff;
  assign ctrl.pat_keep  = !pat_clear;
  assign ctrl.txt_shift = is_txt && in_i.has_byte;
  assign ctrl.txt_clear = (is_txt && in_i.last) || pat_clear;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] pat_in, txt_in;
    logic       pval_in, tval_in;
    if (k == 0) begin : g_head
      assign pat_in  = byte_folded;
      assign pval_in = 1'b1;
      assign txt_in  = byte_folded;
      assign tval_in = 1'b1;
    end else begin : g_body
      assign pat_in  = pat_vec[k-1];
      assign pval_in = pval_vec[k-1];
      assign txt_in  = txt_vec[k-1];
      assign tval_in = tval_vec[k-1];
    end
    ciss_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .pat_i  (pat_in),
      .pval_i (pval_in),
      .txt_i  (txt_in),
      .tval_i (tval_in),
      .pat_o  (pat_vec[k]),
      .pval_o (pval_vec[k]),
      .txt_o  (txt_vec[k]),
      .tval_o (tval_vec[k]),
      .hit_o  (hit_vec[k])
    );
  end

  assign match        = pval_vec[0] && (&hit_vec);
  assign found_now    = found_q || (ctrl.txt_shift && match);
  assign result_found = ovf_q ? 1'b0 : (!pval_vec[0] ? 1'b1 : found_now);
  assign emit         = is_txt && in_i.last;

  always_comb begin
    starting_d = starting_q;
    ovf_d      = ovf_q;
    if (is_pat) begin
      ovf_d = (ovf_q && !pat_clear) || (store_try && full_eff);
      if (in_i.last) begin
        starting_d = 1'b1;
      end else if (in_i.has_byte) begin
        starting_d = 1'b0;
      end
    end
    found_d = found_q;
    if (ctrl.txt_clear) begin
      found_d = 1'b0;
    end else if (ctrl.txt_shift && match) begin
      found_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      starting_q  <= 1'b1;
      ovf_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      starting_q  <= starting_d;
      ovf_q       <= ovf_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_found_q <= result_found;
      out_ovf_q   <= ovf_q;
    end
  end

  assign in_i.ready             = !out_valid_q || out_o.ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.found            = out_found_q;
  assign out_o.pattern_overflow = out_ovf_q;

  `CISS_ASSERT(a_pat_thermo, ((pval_vec >> 1) & ~pval_vec) == '0, "pattern valid bits not contiguous")
  `CISS_ASSERT(a_txt_thermo, ((tval_vec >> 1) & ~tval_vec) == '0, "text valid bits not contiguous")
  `CISS_ASSERT(a_ovf_full, ovf_q |-> (pval_vec[MAX_PATTERN-1] || pat_clear), "overflow without a full pattern")
  `CISS_ASSERT(a_ovf_found, out_valid_q && out_ovf_q |-> !out_found_q, "found with overflow")
  `CISS_ASSERT(a_txt_cleared, emit |=> (tval_vec == '0) && !found_q, "text state kept after result")

endmodule

@@ sim/case_insensitive_substring_search_tb.sv @@
// self-checking testbench for the case-insensitive substring search
module case_insensitive_substring_search_tb;
  import ciss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PATTERN  = 32;
  localparam int LIMIT_CYCLES = 100000;
  localparam int STIM_BEATS   = 475;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    logic       hold_for_drain;
  } search_beat_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } verdict_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       drv_valid  = 1'b0;
  logic       drv_action = ACT_PATTERN;
  logic [7:0] drv_byte   = 8'h00;
  logic       drv_has    = 1'b0;
  logic       drv_last   = 1'b0;
  logic       rx_ready   = 1'b0;

  ciss_in_if  in_bus ();
  ciss_out_if out_bus ();

  assign in_bus.valid     = drv_valid;
  assign in_bus.action    = drv_action;
  assign in_bus.data_byte = drv_byte;
  assign in_bus.has_byte  = drv_has;
  assign in_bus.last      = drv_last;
  assign out_bus.ready    = rx_ready;

  case_insensitive_substring_search #(
    .MAX_PATTERN(MAX_PATTERN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  search_beat_t pending_beats[$];
  search_beat_t next_beat;
  search_beat_t seen_beat;
  verdict_t     expected_verdicts[$];
  verdict_t     want;

  // search state as the block should hold it
  logic [7:0] pat_store[MAX_PATTERN];
  logic [5:0] pat_len;
  logic       pat_fresh;
  logic       pat_ovf;
  logic [7:0] win[MAX_PATTERN];
  logic [5:0] win_fill;
  logic       hit;

  int          mismatch_count = 0;
  logic        drained        = 1'b1;
  logic [15:0] results_seen   = '0;
  logic [3:0]  idle_left      = '0;
  logic        draining       = 1'b0;
  logic        calm           = 1'b0;
  logic [15:0] beats_sent     = '0;
  logic [8:0]  rx_stall       = '0;
  logic        long_hold_done = 1'b0;
  int          cycle_count    = 0;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c | CASE_OFFSET;
    return c;
  endfunction

  function automatic void clear_text();
    foreach (win[k]) win[k] = 8'h00;
    win_fill = '0;
    hit      = 1'b0;
  endfunction

  function automatic void search_step(search_beat_t b);
    logic     leading;
    logic     same;
    verdict_t v;
    if (b.action == ACT_PATTERN) begin
      leading = pat_fresh;
      if (pat_fresh) begin
        pat_len = '0;
        pat_ovf = 1'b0;
        clear_text();
      end
      if (b.has_byte) begin
        pat_fresh = 1'b0;
        if (!(b.data_byte == CHAR_PERCENT && (leading || b.last))) begin
          if (pat_len < MAX_PATTERN) begin
            pat_store[pat_len] = to_lower(b.data_byte);
            pat_len = pat_len + 1'b1;
          end else begin
            pat_ovf = 1'b1;
          end
        end
      end
      if (b.last) pat_fresh = 1'b1;
    end else begin
      if (b.has_byte) begin
        for (int k = MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = to_lower(b.data_byte);
        if (win_fill < MAX_PATTERN) win_fill = win_fill + 1'b1;
        if (pat_len != 0 && win_fill >= pat_len) begin
          same = 1'b1;
          for (int k = 0; k < pat_len; k++) begin
            if (win[k] != pat_store[pat_len - 1 - k]) same = 1'b0;
          end
          if (same) hit = 1'b1;
        end
      end
      if (b.last) begin
        v.overflow = pat_ovf;
        v.found    = pat_ovf ? 1'b0 : (pat_len == 0) ? 1'b1 : hit;
        expected_verdicts.push_back(v);
        clear_text();
      end
    end
  endfunction

  task automatic push_beat(logic act, logic [7:0] d, logic has, logic lst,
                           logic hold = 1'b0);
    search_beat_t b;
    b.action         = act;
    b.data_byte      = d;
    b.has_byte       = has;
    b.last           = lst;
    b.hold_for_drain = hold;
    pending_beats.push_back(b);
  endtask

  // byteless beats are sprinkled in at random
  task automatic push_string(logic act, byte_q_t s, logic hold);
    logic h;
    h = hold;
    if (s.size() == 0) begin
      push_beat(act, 8'($urandom_range(0, 255)), 1'b0, 1'b1, h);
    end else begin
      foreach (s[i]) begin
        if ($urandom_range(0, 11) == 0) begin
          push_beat(act, 8'($urandom_range(0, 255)), 1'b0, 1'b0, h);
          h = 1'b0;
        end
        push_beat(act, s[i], 1'b1, i == s.size() - 1, h);
        h = 1'b0;
      end
    end
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return CHAR_PERCENT;
      3, 4, 5: return 8'($urandom_range(0, 2)) + "A";
      default: return 8'($urandom_range(0, 2)) + "a";
    endcase
  endfunction

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    if (l >= "a" && l <= "z" && $urandom_range(0, 1) == 1) return c ^ CASE_OFFSET;
    return c;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("case_insensitive_substring_search_tb: FAIL");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_action <= ACT_PATTERN;
      drv_byte   <= 8'h00;
      drv_has    <= 1'b0;
      drv_last   <= 1'b0;
      idle_left  <= '0;
      draining   <= 1'b0;
      calm       <= 1'b0;
      beats_sent <= '0;
    end else begin
      calm <= pending_beats.size() < 60;
      if (!drv_valid || in_bus.ready) begin
        if (idle_left != 0) begin
          drv_valid <= 1'b0;
          idle_left <= idle_left - 1'b1;
        end else if (draining) begin
          drv_valid <= 1'b0;
          if (drained) draining <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          drv_valid <= 1'b0;
        end else if (pending_beats[0].hold_for_drain) begin
          pending_beats[0].hold_for_drain = 1'b0;
          draining  <= 1'b1;
          drv_valid <= 1'b0;
        end else begin
          next_beat  = pending_beats.pop_front();
          drv_valid  <= 1'b1;
          drv_action <= next_beat.action;
          drv_byte   <= next_beat.data_byte;
          drv_has    <= next_beat.has_byte;
          drv_last   <= next_beat.last;
          beats_sent <= beats_sent + 1'b1;
          if (!calm && beats_sent[5] && $urandom_range(0, 5) == 0)
            idle_left <= 4'($urandom_range(1, 10));
        end
      end
    end
  end

  // receiver, with one long hold-off once a dozen results are in
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready       <= 1'b0;
      rx_stall       <= '0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && results_seen == 12) begin
      rx_ready       <= 1'b0;
      rx_stall       <= 9'd400;
      long_hold_done <= 1'b1;
    end else if (rx_stall != 0) begin
      rx_ready <= 1'b0;
      rx_stall <= rx_stall - 1'b1;
    end else if (!calm && results_seen[3] && $urandom_range(0, 7) == 0) begin
      rx_ready <= 1'b0;
      rx_stall <= 9'($urandom_range(0, 9));
    end else begin
      rx_ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len   = '0;
      pat_fresh = 1'b1;
      pat_ovf   = 1'b0;
      clear_text();
      expected_verdicts.delete();
      drained      <= 1'b1;
      results_seen <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        seen_beat.action         = in_bus.action;
        seen_beat.data_byte      = in_bus.data_byte;
        seen_beat.has_byte       = in_bus.has_byte;
        seen_beat.last           = in_bus.last;
        seen_beat.hold_for_drain = 1'b0;
        search_step(seen_beat);
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen <= results_seen + 1'b1;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result beat, found %0b overflow %0b", $time,
                   out_bus.found, out_bus.pattern_overflow);
          mismatch_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_bus.found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found,
                     out_bus.found);
            mismatch_count++;
          end
          if (out_bus.pattern_overflow !== want.overflow) begin
            $display("%0t: pattern_overflow expected %0b actual %0b", $time,
                     want.overflow, out_bus.pattern_overflow);
            mismatch_count++;
          end
        end
      end
      drained <= expected_verdicts.size() == 0;
    end
  end

  initial begin
    int      scen;
    int      sel;
    int      plen;
    int      cut;
    logic    hold;
    byte_q_t core;
    byte_q_t pat;
    byte_q_t txt;

    // empty text against empty pattern
    push_beat(ACT_TEXT, 8'h00, 1'b0, 1'b1);
    // lone percent
    push_beat(ACT_PATTERN, CHAR_PERCENT, 1'b1, 1'b1);
    push_beat(ACT_TEXT, "q", 1'b1, 1'b1);
    push_beat(ACT_PATTERN, CHAR_PERCENT, 1'b1, 1'b0);
    push_beat(ACT_PATTERN, CHAR_PERCENT, 1'b1, 1'b1);
    push_beat(ACT_TEXT, 8'hff, 1'b0, 1'b1);
    // percent on both ends, letter and non-letter neighbors of the upper range
    push_beat(ACT_PATTERN, CHAR_PERCENT, 1'b1, 1'b0);
    push_beat(ACT_PATTERN, "A", 1'b1, 1'b0);
    push_beat(ACT_PATTERN, "[", 1'b1, 1'b0);
    push_beat(ACT_PATTERN, CHAR_PERCENT, 1'b1, 1'b1);
    push_beat(ACT_TEXT, "@", 1'b1, 1'b0);
    push_beat(ACT_TEXT, "a", 1'b1, 1'b0);
    push_beat(ACT_TEXT, "[", 1'b1, 1'b1);
    // byte extremes, byteless beats, text shorter than pattern
    push_beat(ACT_PATTERN, 8'hff, 1'b0, 1'b0);
    push_beat(ACT_PATTERN, 8'h00, 1'b1, 1'b0);
    push_beat(ACT_PATTERN, 8'hff, 1'b1, 1'b1);
    push_beat(ACT_TEXT, "Z", 1'b1, 1'b0);
    push_beat(ACT_TEXT, 8'h00, 1'b0, 1'b0);
    push_beat(ACT_TEXT, 8'hff, 1'b1, 1'b1);
    push_beat(ACT_TEXT, 8'h00, 1'b1, 1'b1);
    // text in the middle of a pattern
    push_beat(ACT_PATTERN, "z", 1'b1, 1'b0);
    push_beat(ACT_TEXT, "Z", 1'b1, 1'b1);
    push_beat(ACT_PATTERN, "y", 1'b1, 1'b1);
    push_beat(ACT_TEXT, "z", 1'b1, 1'b0);
    push_beat(ACT_TEXT, "Y", 1'b1, 1'b1);

    for (scen = 0; pending_beats.size() < STIM_BEATS; scen++) begin
      hold = (scen == 1) || (scen % 9 == 5);
      sel  = (scen == 3) ? 1 : $urandom_range(0, 19);
      if (sel == 0) begin
        repeat ($urandom_range(1, 6)) begin
          push_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), hold);
          hold = 1'b0;
        end
      end else begin
        plen = (sel == 1) ? $urandom_range(30, 38) : $urandom_range(0, 6);
        core.delete();
        repeat (plen) core.push_back(pick_char());
        pat = core;
        if ($urandom_range(0, 3) == 0) pat.push_front(CHAR_PERCENT);
        if ($urandom_range(0, 3) == 0) pat.push_back(CHAR_PERCENT);
        if (sel == 2 && pat.size() >= 2) begin
          cut = $urandom_range(1, pat.size() - 1);
          for (int i = 0; i < cut; i++) push_beat(ACT_PATTERN, pat[i], 1'b1, 1'b0, hold && i == 0);
          txt.delete();
          repeat ($urandom_range(0, 6)) txt.push_back(pick_char());
          for (int i = 0; i < cut; i++) txt.push_back(mixed_case(pat[i]));
          push_string(ACT_TEXT, txt, 1'b0);
          for (int i = cut; i < pat.size(); i++)
            push_beat(ACT_PATTERN, pat[i], 1'b1, i == pat.size() - 1);
        end else begin
          push_string(ACT_PATTERN, pat, hold);
        end
        repeat ($urandom_range(1, 3)) begin
          txt.delete();
          repeat ($urandom_range(0, 8)) txt.push_back(pick_char());
          if ($urandom_range(0, 2) != 0)
            foreach (core[i]) txt.push_back(mixed_case(core[i]));
          repeat ($urandom_range(0, 8)) txt.push_back(pick_char());
          push_string(ACT_TEXT, txt, 1'b0);
        end
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_beats.size() != 0 || drv_valid || draining || !drained);
    repeat (20) @(negedge clk_i);

    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("case_insensitive_substring_search_tb: PASS");
    end else begin
      $display("case_insensitive_substring_search_tb: FAIL");
    end
    $finish;
  end

endmodule
